// ===== design/sle_pkg.sv =====
// Shared types and codes for the sorted list engine.
package sle_pkg;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_INSERT   = 3'd0;
    localparam logic [2:0] KIND_REMOVE   = 3'd1;
    localparam logic [2:0] KIND_REPLACE  = 3'd2;
    localparam logic [2:0] KIND_RETRIEVE = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    // Status codes returned with each result word
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_RANGE     = 3'd4;

    typedef struct packed {
        logic        [2:0]  kind;
        logic signed [31:0] value;
        logic        [6:0]  position;
    } sle_in_t;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [31:0] read_value;
        logic        [6:0]  entry_count;
    } sle_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_EV,
        S_INS_TAIL,
        S_SRCH,
        S_SRCH_EV,
        S_MATCH_EV,
        S_SHIFT_RD,
        S_SHIFT_EV,
        S_RET_EV,
        S_DONE
    } sle_state_t;

endpackage

// ===== design/sle_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: sequencer around one entry memory.
//
// Keeps up to CAPACITY signed 32-bit entries in ascending order in one RAM
// with a registered read. One input word is taken at a time, and each
// yields one result word. Every memory read takes an address state and then
// an evaluate state. An insert into n entries walks all n of them. A remove
// binary-searches for its value, with the number of search steps at most
// ceil(log2(n)), and on a match shifts every entry above it down one slot.
// Replace, clear, unknown kinds, insert into a full list and remove from an
// empty one go from decode straight to done, and a retrieve in range adds
// one evaluate state. Removing the first of 64 entries is the slowest item.
// The next input word is taken while a result word still waits on the
// output. That item then holds in its last state until the output register
// is free. Entries come out of reset undefined. No clearing pass is run,
// since only positions below the entry count are ever used.
module sorted_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sle_pkg::sle_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sle_pkg::sle_out_t m_data
);
    import sle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    sle_state_t         state_reg, state_next;
    sle_in_t            item_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      lo_reg, lo_next;
    logic [IW-1:0]      hi_reg, hi_next;
    logic signed [31:0] carry_reg, carry_next;
    logic               found_reg, found_next;
    logic [2:0]         stat_reg, stat_next;
    logic signed [31:0] rd_reg, rd_next;
    sle_out_t           out_reg;
    logic               m_valid_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    logic signed [31:0] d;
    logic signed [31:0] v;
    logic [CW-1:0]      k_ext;
    logic [CW-1:0]      k_plus1;
    logic               ins_gt;
    logic               ins_place;
    logic               ins_last;
    logic               list_full;
    logic               list_empty;
    logic [IW:0]        lo_hi_sum;
    logic [IW-1:0]      mid;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_pw;
    logic               pos_ok;
    logic [IW-1:0]      pos_idx;
    logic               out_free;

    sle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared conditions
    assign d          = $signed(ram_rdata);
    assign v          = item_reg.value;
    assign k_ext      = CW'(k_reg);
    assign k_plus1    = k_ext + CW'(1);
    assign ins_gt     = v > d;
    assign ins_place  = found_reg || !ins_gt;
    assign ins_last   = (k_plus1 == count_reg);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign lo_hi_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = lo_hi_sum[IW:1];
    assign pos_ext    = PW'(item_reg.position);
    assign cnt_pw     = PW'(count_reg);
    assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_pw);
    assign pos_idx    = IW'(pos_ext - PW'(1));
    assign out_free   = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (item_reg.kind)
                    KIND_INSERT: begin
                        if (list_full) begin
                            state_next = S_DONE;
                        end else if (list_empty) begin
                            state_next = S_INS_TAIL;
                        end else begin
                            state_next = S_INS_RD;
                        end
                    end
                    KIND_REMOVE: begin
                        state_next = list_empty ? S_DONE : S_SRCH;
                    end
                    KIND_RETRIEVE: begin
                        state_next = pos_ok ? S_RET_EV : S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_RD:   state_next = S_INS_EV;
            S_INS_EV:   state_next = ins_last ? S_INS_TAIL : S_INS_RD;
            S_INS_TAIL: state_next = S_DONE;
            S_SRCH:     state_next = (lo_reg < hi_reg) ? S_SRCH_EV : S_MATCH_EV;
            S_SRCH_EV:  state_next = S_SRCH;
            S_MATCH_EV: state_next = (d == v) ? S_SHIFT_RD : S_DONE;
            S_SHIFT_RD: state_next = (k_plus1 < count_reg) ? S_SHIFT_EV : S_DONE;
            S_SHIFT_EV: state_next = S_SHIFT_RD;
            S_RET_EV:   state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory and handshake controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = carry_reg;
        ram_raddr = k_reg;
        s_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_DECODE: begin
                ram_raddr = pos_idx;
                if (item_reg.kind == KIND_REPLACE && pos_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_idx;
                    ram_wdata = item_reg.value;
                end
            end
            S_INS_EV: begin
                ram_we = ins_place;
            end
            S_INS_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(count_reg);
            end
            S_SRCH: begin
                ram_raddr = (lo_reg < hi_reg) ? mid : hi_reg;
            end
            S_SHIFT_RD: begin
                ram_raddr = IW'(k_plus1);
            end
            S_SHIFT_EV: begin
                ram_we    = 1'b1;
                ram_wdata = d;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        count_next = count_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        carry_next = carry_reg;
        found_next = found_reg;
        stat_next  = stat_reg;
        rd_next    = rd_reg;
        case (state_reg)
            S_DECODE: begin
                stat_next  = STAT_OK;
                rd_next    = '0;
                k_next     = '0;
                found_next = 1'b0;
                carry_next = item_reg.value;
                lo_next    = '0;
                hi_next    = IW'(count_reg - CW'(1));
                case (item_reg.kind)
                    KIND_INSERT: begin
                        if (list_full) begin
                            stat_next = STAT_FULL;
                        end
                    end
                    KIND_REMOVE: begin
                        if (list_empty) begin
                            stat_next = STAT_EMPTY;
                        end
                    end
                    KIND_REPLACE, KIND_RETRIEVE: begin
                        if (!pos_ok) begin
                            stat_next = STAT_RANGE;
                        end
                    end
                    KIND_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_EV: begin
                // Carry the displaced entry up one slot
                if (ins_place) begin
                    carry_next = d;
                    found_next = 1'b1;
                end
                k_next = IW'(k_plus1);
            end
            S_INS_TAIL: begin
                count_next = count_reg + CW'(1);
            end
            S_SRCH_EV: begin
                if (d < v) begin
                    lo_next = mid + IW'(1);
                end else begin
                    hi_next = mid;
                end
            end
            S_MATCH_EV: begin
                k_next = hi_reg;
                if (d != v) begin
                    stat_next = STAT_NOT_FOUND;
                end
            end
            S_SHIFT_RD: begin
                if (!(k_plus1 < count_reg)) begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_SHIFT_EV: begin
                k_next = IW'(k_plus1);
            end
            S_RET_EV: begin
                rd_next = d;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        carry_reg <= carry_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
        rd_reg    <= rd_next;
        if (state_reg == S_DONE && out_free) begin
            out_reg.status      <= stat_reg;
            out_reg.read_value  <= rd_reg;
            out_reg.entry_count <= cnt_pw[6:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
